// ----- sv/waypoint_follower_3d_top_defines.svh -----
// ----------------------------------------------------------------------------
// Waypoint follower assertion macros
// Shared property wrappers on aclk with reset disable.
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_FOLLOWER_3D_TOP_DEFINES_SVH
`define WAYPOINT_FOLLOWER_3D_TOP_DEFINES_SVH

// Same-cycle implication.
`define WF3D_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WF3D_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/wf3d_pkg.sv -----
// ----------------------------------------------------------------------------
// Waypoint follower package
// Widths, codes and shared types of the 3D waypoint follower.
// ----------------------------------------------------------------------------
`default_nettype none

package wf3d_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam int COORD_W  = 32;
    localparam int MAG_W    = COORD_W + 1;   // magnitude of a coordinate difference
    localparam int PROD_W   = 2 * MAG_W;     // product and radicand width
    localparam int SPEED_W  = 24;
    localparam int DT_W     = 16;
    localparam int FRAC_W   = 16;
    localparam int STEP_W   = 24;
    localparam int KIND_W   = 2;
    localparam int TIDX_W   = 6;
    localparam int PCNT_W   = 7;
    localparam int STAT_W   = 3;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 112;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 24'd65536;
    localparam logic [MAG_W-1:0]   EPS_Q16     = 33'd66;

    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] ST_MOVING  = 3'd0;
    localparam logic [STAT_W-1:0] ST_ARRIVED = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STAT_W-1:0] ST_APPEND  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;
    localparam logic [STAT_W-1:0] ST_CLEARED = 3'd5;

    // Status of an iterative arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

// ----- sv/wf3d_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wf3d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/wf3d_mul.sv -----
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Unsigned shift-add multiply, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wf3d_mul (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [wf3d_pkg::MAG_W-1:0]   a,
    input  wire logic [wf3d_pkg::MAG_W-1:0]   b,
    output logic      [wf3d_pkg::PROD_W-1:0]  prod,
    output wf3d_pkg::unit_stat_t              stat
);
    import wf3d_pkg::*;

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [PROD_W-1:0] acc_reg, a_sh_reg;
    logic [MAG_W-1:0]  b_sh_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg, done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                acc_reg  <= '0;
                a_sh_reg <= PROD_W'(a);
                b_sh_reg <= b;
                cnt_reg  <= CNT_W'(MAG_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (b_sh_reg[0]) begin
                    acc_reg <= acc_reg + a_sh_reg;
                end
                a_sh_reg <= a_sh_reg << 1;
                b_sh_reg <= b_sh_reg >> 1;
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign prod      = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ----- sv/wf3d_sqrt.sv -----
// ----------------------------------------------------------------------------
// Digit-serial square root
// Restoring integer square root, one root bit (two radicand bits) per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wf3d_sqrt (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [wf3d_pkg::PROD_W-1:0]  radicand,
    output logic      [wf3d_pkg::MAG_W-1:0]   root,
    output wf3d_pkg::unit_stat_t              stat
);
    import wf3d_pkg::*;

    localparam int CNT_W = $clog2(MAG_W + 1);
    localparam int REM_W = MAG_W + 3;

    logic [PROD_W-1:0] rad_reg;
    logic [MAG_W-1:0]  root_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg, done_reg;

    logic [REM_W-1:0]  rem_sh, trial, rem_sub;
    logic              ge;

    always_comb begin
        rem_sh  = {rem_reg[REM_W-3:0], rad_reg[PROD_W-1 -: 2]};
        trial   = REM_W'({root_reg, 2'b01});
        ge      = rem_sh >= trial;
        rem_sub = rem_sh - trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                rad_reg  <= radicand;
                root_reg <= '0;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(MAG_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= ge ? rem_sub : rem_sh;
                root_reg <= {root_reg[MAG_W-2:0], ge};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ----- sv/wf3d_div.sv -----
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wf3d_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [wf3d_pkg::PROD_W-1:0]  dividend,
    input  wire logic [wf3d_pkg::MAG_W-1:0]   divisor,
    output logic      [wf3d_pkg::MAG_W-1:0]   quotient,
    output wf3d_pkg::unit_stat_t              stat
);
    import wf3d_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] dvd_reg;
    logic [MAG_W-1:0]  dvs_reg, rem_reg, quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg, done_reg;

    logic [MAG_W:0]    rem_sh, rem_sub;
    logic              ge;

    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[PROD_W-1]};
        ge      = rem_sh >= {1'b0, dvs_reg};
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= CNT_W'(PROD_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                dvd_reg <= dvd_reg << 1;
                rem_reg <= ge ? rem_sub[MAG_W-1:0] : rem_sh[MAG_W-1:0];
                // The quotient never exceeds the scaled axis magnitude, so high bits drop.
                quo_reg <= {quo_reg[MAG_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ----- sv/waypoint_follower_3d_top.sv -----
// ----------------------------------------------------------------------------
// 3D waypoint follower
// Constant-speed follower over a cyclic table of Q16.16 waypoints.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one item per transfer; s_tuser is the item kind
//   (tick, append, clear). Every item yields one result on the m_ channel:
//   position, target index and table count in m_tdata, status in m_tuser.
//   cfg_valid/cfg_data writes the move speed; cfg_ready is always high.
// Processing:
//   Append, clear, unused kind and tick on an empty table go straight to
//   the result. A tick that arrives runs three squares, a square root and
//   a step multiply; a tick that moves adds a per-axis scale multiply and
//   divide. All of this runs through one bit-serial multiplier, one
//   bit-serial square root and one bit-serial divider. One item is in work
//   at a time; the next is taken once the result has been placed in the
//   output register.
// Reset clears position, target and count and sets the speed to 1.0.
// When the receiver stalls the result is held and the next item is still
// taken; a finished item then waits until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "waypoint_follower_3d_top_defines.svh"

module waypoint_follower_3d_top #(
    parameter int MAX_POINTS = wf3d_pkg::MAX_POINTS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration: move_speed
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [wf3d_pkg::SPEED_W-1:0]     cfg_data,
    // Input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // s_tdata from bit 0: delta_time[15:0], point_x[47:16], point_y[79:48],
    // point_z[111:80]
    input  wire logic [wf3d_pkg::IN_DATA_W-1:0]   s_tdata,
    // s_tuser: kind[1:0]
    input  wire logic [wf3d_pkg::KIND_W-1:0]      s_tuser,
    // Result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata from bit 0: pos_x[31:0], pos_y[63:32], pos_z[95:64],
    // target_index[101:96], point_count[108:102], zero fill
    output logic      [wf3d_pkg::OUT_DATA_W-1:0]  m_tdata,
    // m_tuser: status[2:0]
    output logic      [wf3d_pkg::STAT_W-1:0]      m_tuser
);
    import wf3d_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int WP_W = 3 * COORD_W;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_LOAD, S_SQ, S_SQW, S_SQRT, S_SQRTW, S_STEP, S_STEPW,
        S_DECIDE, S_MV, S_MVW, S_DV, S_DVW, S_DONE
    } state_t;

    state_t             state_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [CW-1:0]      cnt_reg;
    logic [AW-1:0]      tgt_reg;
    logic [COORD_W-1:0] pos_reg [3];
    logic [COORD_W-1:0] wp_reg  [3];
    logic [MAG_W-1:0]   mag_reg [3];
    logic [2:0]         neg_reg;
    logic [1:0]         axis_reg;
    logic [DT_W-1:0]    dt_reg;
    logic [PROD_W-1:0]  sum_reg;
    logic [MAG_W-1:0]   dist_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [STAT_W-1:0]  status_reg;

    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic [STAT_W-1:0]       m_tuser_reg;

    logic                    s_fire;
    logic                    ram_we;
    logic [WP_W-1:0]         ram_rdata;
    logic [COORD_W-1:0]      ram_wp [3];

    logic [MAG_W-1:0]        mul_a, mul_b, root, quot;
    logic [PROD_W-1:0]       prod;
    unit_stat_t              mul_stat, sqrt_stat, div_stat;

    logic [MAG_W-1:0]        diff_s [3];
    logic [CW-1:0]           tgt_inc;
    logic [COORD_W-1:0]      q_sgn;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign ram_we    = s_fire && (s_tuser == KIND_APPEND) && (cnt_reg < CW'(MAX_POINTS));

    wf3d_ram #(.WIDTH(WP_W), .DEPTH(MAX_POINTS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (s_tdata[DT_W +: WP_W]),
        .raddr (tgt_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ram_wp[i] = ram_rdata[i*COORD_W +: COORD_W];
            diff_s[i] = {ram_wp[i][COORD_W-1], ram_wp[i]} - {pos_reg[i][COORD_W-1], pos_reg[i]};
        end
        tgt_inc = CW'(tgt_reg) + 1'b1;
        q_sgn   = neg_reg[axis_reg] ? (~quot[COORD_W-1:0] + 1'b1) : quot[COORD_W-1:0];
    end

    always_comb begin
        case (state_reg)
            S_STEP: begin
                mul_a = MAG_W'(speed_reg);
                mul_b = MAG_W'(dt_reg);
            end
            S_MV: begin
                mul_a = mag_reg[axis_reg];
                mul_b = MAG_W'(step_reg);
            end
            default: begin
                mul_a = mag_reg[axis_reg];
                mul_b = mag_reg[axis_reg];
            end
        endcase
    end

    wf3d_mul u_mul (
        .aclk (aclk), .aresetn (aresetn),
        .start (state_reg == S_SQ || state_reg == S_STEP || state_reg == S_MV),
        .a (mul_a), .b (mul_b), .prod (prod), .stat (mul_stat)
    );

    wf3d_sqrt u_sqrt (
        .aclk (aclk), .aresetn (aresetn),
        .start (state_reg == S_SQRT),
        .radicand (sum_reg), .root (root), .stat (sqrt_stat)
    );

    wf3d_div u_div (
        .aclk (aclk), .aresetn (aresetn),
        .start (state_reg == S_DV),
        .dividend (prod), .divisor (dist_reg), .quotient (quot), .stat (div_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            speed_reg    <= SPEED_RESET;
            cnt_reg      <= '0;
            tgt_reg      <= '0;
            for (int i = 0; i < 3; i++) pos_reg[i] <= '0;
            m_tvalid_reg <= 1'b0;
            axis_reg     <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                speed_reg <= cfg_data;
            end
            // In S_DONE the output register is handled by the state itself.
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        dt_reg <= s_tdata[DT_W-1:0];
                        case (s_tuser)
                            KIND_TICK: begin
                                if (cnt_reg == '0 || CW'(tgt_reg) >= cnt_reg) begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_DONE;
                                end else begin
                                    state_reg <= S_RD;
                                end
                            end
                            KIND_APPEND: begin
                                state_reg <= S_DONE;
                                if (cnt_reg >= CW'(MAX_POINTS)) begin
                                    status_reg <= ST_FULL;
                                end else begin
                                    cnt_reg    <= cnt_reg + 1'b1;
                                    status_reg <= ST_APPEND;
                                end
                            end
                            KIND_CLEAR: begin
                                cnt_reg    <= '0;
                                tgt_reg    <= '0;
                                status_reg <= ST_CLEARED;
                                state_reg  <= S_DONE;
                            end
                            default: begin
                                status_reg <= ST_MOVING;
                                state_reg  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    state_reg <= S_LOAD;
                end
                S_LOAD: begin
                    for (int i = 0; i < 3; i++) begin
                        wp_reg[i]  <= ram_wp[i];
                        neg_reg[i] <= diff_s[i][MAG_W-1];
                        mag_reg[i] <= diff_s[i][MAG_W-1] ? (~diff_s[i] + 1'b1) : diff_s[i];
                    end
                    sum_reg   <= '0;
                    axis_reg  <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ: begin
                    state_reg <= S_SQW;
                end
                S_SQW: begin
                    if (mul_stat.done) begin
                        sum_reg <= sum_reg + prod;
                        if (axis_reg == 2'd2) begin
                            state_reg <= S_SQRT;
                        end else begin
                            axis_reg  <= axis_reg + 1'b1;
                            state_reg <= S_SQ;
                        end
                    end
                end
                S_SQRT: begin
                    state_reg <= S_SQRTW;
                end
                S_SQRTW: begin
                    if (sqrt_stat.done) begin
                        dist_reg  <= root;
                        state_reg <= S_STEP;
                    end
                end
                S_STEP: begin
                    state_reg <= S_STEPW;
                end
                S_STEPW: begin
                    if (mul_stat.done) begin
                        step_reg  <= prod[FRAC_W +: STEP_W];
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (dist_reg < EPS_Q16 || MAG_W'(step_reg) >= dist_reg) begin
                        for (int i = 0; i < 3; i++) pos_reg[i] <= wp_reg[i];
                        tgt_reg    <= (tgt_inc >= cnt_reg) ? '0 : tgt_inc[AW-1:0];
                        status_reg <= ST_ARRIVED;
                        state_reg  <= S_DONE;
                    end else begin
                        axis_reg   <= '0;
                        status_reg <= ST_MOVING;
                        state_reg  <= S_MV;
                    end
                end
                S_MV: begin
                    state_reg <= S_MVW;
                end
                S_MVW: begin
                    if (mul_stat.done) begin
                        state_reg <= S_DV;
                    end
                end
                S_DV: begin
                    state_reg <= S_DVW;
                end
                S_DVW: begin
                    if (div_stat.done) begin
                        pos_reg[axis_reg] <= pos_reg[axis_reg] + q_sgn;
                        if (axis_reg == 2'd2) begin
                            state_reg <= S_DONE;
                        end else begin
                            axis_reg  <= axis_reg + 1'b1;
                            state_reg <= S_MV;
                        end
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {3'b000, PCNT_W'(cnt_reg), TIDX_W'(tgt_reg),
                                         pos_reg[2], pos_reg[1], pos_reg[0]};
                        m_tuser_reg  <= status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `WF3D_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CW'(MAX_POINTS), "point count above table size")
    `WF3D_ASSERT_NOW(a_tgt_bound, cnt_reg != '0, CW'(tgt_reg) < cnt_reg, "target beyond count")
    `WF3D_ASSERT_NXT(a_one_item, s_fire, !s_tready, "second item taken while one is in work")
    `WF3D_ASSERT_NOW(a_units_idle, s_tready, !mul_stat.busy && !sqrt_stat.busy && !div_stat.busy,
        "arithmetic unit busy while idle")

endmodule

`default_nettype wire

// ----- verif/tb_waypoint_follower_3d_top.sv -----
// ----------------------------------------------------------------------------
// Waypoint follower testbench
// Drives ticks, appends and clears into the 3D waypoint follower. A local
// model of the position, target and table works out each expected result,
// and results are compared field by field in order. The sender idles in
// bursts and the receiver stalls on its own pattern. The speed register is
// written between phases, including its extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_waypoint_follower_3d_top;
    import wf3d_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int TARGET_ITEMS = 900;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam logic [34:0] EPS_DIST = 35'd66;

    typedef struct packed {
        logic [31:0]       x;
        logic [31:0]       y;
        logic [31:0]       z;
        logic [TIDX_W-1:0] tidx;
        logic [PCNT_W-1:0] cnt;
        logic [STAT_W-1:0] stat;
    } pose_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [15:0]       dt;
        logic [31:0]       px;
        logic [31:0]       py;
        logic [31:0]       pz;
        bit                typed;
        pose_t             want;
    } step_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [SPEED_W-1:0]    cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]     m_tuser;

    waypoint_follower_3d_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Follower state as the testbench sees it.
    logic [31:0]        table_x[MAX_POINTS_DEF];
    logic [31:0]        table_y[MAX_POINTS_DEF];
    logic [31:0]        table_z[MAX_POINTS_DEF];
    logic [31:0]        cur_x, cur_y, cur_z;
    logic [TIDX_W-1:0]  cur_tgt;
    logic [PCNT_W-1:0]  cur_cnt;
    logic [SPEED_W-1:0] cur_speed;

    pose_t pending_poses[$];
    int    errors;
    int    cycles;
    int    items_sent;
    int    burst_left;
    int    gap_len;
    int    rdy_mode;
    int    rdy_left;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycles);
        errors++;
    endtask

    task automatic queue_pose(input pose_t p);
        pending_poses.insert(pending_poses.size(), p);
    endtask

    function automatic logic [31:0] step_axis(input logic [31:0] pos, input logic [32:0] d,
                                              input logic [39:0] step, input logic [34:0] dist_len);
        logic [63:0] mag;
        logic [63:0] q;
        logic [32:0] p;
        mag = d[32] ? {31'b0, -d} : {31'b0, d};
        q = mag * step / dist_len;
        p = d[32] ? {pos[31], pos} - q[32:0] : {pos[31], pos} + q[32:0];
        return p[31:0];
    endfunction

    task automatic follow_item(input logic [KIND_W-1:0] kind, input logic [15:0] dt,
                               input logic [31:0] px, input logic [31:0] py,
                               input logic [31:0] pz, output pose_t r);
        logic [32:0] dx, dy, dz;
        logic [67:0] mx, my, mz, sum;
        logic [34:0] root, cand;
        logic [69:0] cw;
        logic [39:0] prod, step;
        logic [STAT_W-1:0] st;
        int t;
        st = ST_MOVING;
        if (kind == KIND_TICK) begin
            if (cur_cnt == 0 || {1'b0, cur_tgt} >= cur_cnt) begin
                st = ST_EMPTY;
            end else begin
                t = cur_tgt;
                dx = {table_x[t][31], table_x[t]} - {cur_x[31], cur_x};
                dy = {table_y[t][31], table_y[t]} - {cur_y[31], cur_y};
                dz = {table_z[t][31], table_z[t]} - {cur_z[31], cur_z};
                mx = dx[32] ? {35'b0, -dx} : {35'b0, dx};
                my = dy[32] ? {35'b0, -dy} : {35'b0, dy};
                mz = dz[32] ? {35'b0, -dz} : {35'b0, dz};
                sum = mx * mx + my * my + mz * mz;
                root = '0;
                for (int b = 34; b >= 0; b--) begin
                    cand = root | (35'd1 << b);
                    cw = {35'b0, cand};
                    if (cw * cw <= {2'b0, sum}) root = cand;
                end
                prod = {16'b0, cur_speed} * {24'b0, dt};
                step = prod >> 16;
                if (root < EPS_DIST || step >= {5'b0, root}) begin
                    cur_x = table_x[t];
                    cur_y = table_y[t];
                    cur_z = table_z[t];
                    cur_tgt = (t + 1 >= cur_cnt) ? '0 : TIDX_W'(t + 1);
                    st = ST_ARRIVED;
                end else begin
                    cur_x = step_axis(cur_x, dx, step, root);
                    cur_y = step_axis(cur_y, dy, step, root);
                    cur_z = step_axis(cur_z, dz, step, root);
                end
            end
        end else if (kind == KIND_APPEND) begin
            if (cur_cnt >= MAX_POINTS_DEF) begin
                st = ST_FULL;
            end else begin
                table_x[cur_cnt] = px;
                table_y[cur_cnt] = py;
                table_z[cur_cnt] = pz;
                cur_cnt++;
                st = ST_APPEND;
            end
        end else if (kind == KIND_CLEAR) begin
            cur_cnt = '0;
            cur_tgt = '0;
            st = ST_CLEARED;
        end
        r = '{x: cur_x, y: cur_y, z: cur_z, tidx: cur_tgt, cnt: cur_cnt, stat: st};
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [15:0] dt,
                             input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input bit typed, input pose_t want);
        pose_t r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_len = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap_len > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap_len) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {pz, py, px, dt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        follow_item(kind, dt, px, py, pz, r);
        queue_pose(typed ? want : r);
        if (kind != KIND_UNUSED) items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_plain(input logic [KIND_W-1:0] kind, input logic [15:0] dt,
                              input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz);
        send_item(kind, dt, px, py, pz, 1'b0, '0);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_poses.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_speed(input logic [SPEED_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cur_speed = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_coord;
        // Mostly within a few units so that arrivals happen often.
        if ($urandom_range(7) == 0) return $urandom;
        return $urandom_range(0, 32'h000A0000) - 32'h00050000;
    endfunction

    function automatic logic [15:0] pick_dt;
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Receiver stall pattern: runs of always ready, mostly ready and mostly stalled.
    always @(negedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(2);
            rdy_left = $urandom_range(32, 400);
        end else begin
            rdy_left--;
        end
        case (rdy_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(3) != 0);
            default: m_tready <= ($urandom_range(5) == 0);
        endcase
    end

    always @(posedge aclk) begin
        pose_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_poses.size() == 0) begin
                report("unexpected result", m_tdata[31:0], '0);
            end else begin
                w = pending_poses.pop_front();
                if (m_tdata[31:0] !== w.x) report("pos_x", m_tdata[31:0], w.x);
                if (m_tdata[63:32] !== w.y) report("pos_y", m_tdata[63:32], w.y);
                if (m_tdata[95:64] !== w.z) report("pos_z", m_tdata[95:64], w.z);
                if (m_tdata[101:96] !== w.tidx)
                    report("target_index", 32'(m_tdata[101:96]), 32'(w.tidx));
                if (m_tdata[108:102] !== w.cnt)
                    report("point_count", 32'(m_tdata[108:102]), 32'(w.cnt));
                if (m_tuser !== w.stat) report("status", 32'(m_tuser), 32'(w.stat));
            end
        end
    end

    step_row_t opening[] = '{
        '{KIND_TICK, 16'hFFFF, 32'h0, 32'h0, 32'h0, 1'b1, '{0, 0, 0, 0, 0, ST_EMPTY}},
        '{KIND_UNUSED, 16'hFFFF, '1, '1, '1, 1'b1, '{0, 0, 0, 0, 0, ST_MOVING}},
        '{KIND_APPEND, 16'h0, 32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b1,
          '{0, 0, 0, 0, 1, ST_APPEND}},
        '{KIND_TICK, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
        '{KIND_TICK, 16'hFFFF, '1, '1, '1, 1'b0, '0},
        '{KIND_CLEAR, 16'h1234, 32'h0, 32'h0, 32'h0, 1'b0, '0},
        '{KIND_TICK, 16'hFFFF, 32'h0, 32'h0, 32'h0, 1'b0, '0},
        '{KIND_APPEND, 16'h0, 32'h00010000, 32'h0, 32'h0, 1'b0, '0},
        '{KIND_APPEND, 16'h0, 32'h0, 32'h0, 32'h00010000, 1'b0, '0},
        '{KIND_APPEND, 16'h0, 32'h00000020, 32'h00000010, 32'h00010000, 1'b0, '0},
        '{KIND_TICK, 16'h8000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
        '{KIND_TICK, 16'hFFFF, 32'h0, 32'h0, 32'h0, 1'b0, '0},
        '{KIND_TICK, 16'hFFFF, 32'h0, 32'h0, 32'h0, 1'b0, '0},
        '{KIND_TICK, 16'hFFFF, 32'h0, 32'h0, 32'h0, 1'b0, '0},
        '{KIND_TICK, 16'hFFFF, 32'h0, 32'h0, 32'h0, 1'b0, '0},
        // The target has wrapped to the first waypoint, beyond the epsilon, so a zero step stays put.
        '{KIND_TICK, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
        '{KIND_TICK, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
        '{KIND_TICK, 16'hFFFF, 32'h0, 32'h0, 32'h0, 1'b0, '0}
    };

    initial begin
        int n;
        int episode;
        logic [SPEED_W-1:0] speeds[5];
        errors = 0;
        cycles = 0;
        items_sent = 0;
        burst_left = 0;
        rdy_mode = 0;
        rdy_left = 0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cur_x = '0; cur_y = '0; cur_z = '0;
        cur_tgt = '0; cur_cnt = '0;
        cur_speed = SPEED_RESET;
        for (int i = 0; i < MAX_POINTS_DEF; i++) begin
            table_x[i] = '0; table_y[i] = '0; table_z[i] = '0;
        end
        speeds = '{24'd0, 24'hFFFFFF, SPEED_RESET, 24'h000800, 24'h040000};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (opening[i])
            send_item(opening[i].kind, opening[i].dt, opening[i].px, opening[i].py,
                      opening[i].pz, opening[i].typed, opening[i].want);

        // The sender holds off here until every result is back.
        write_speed(24'hFFFFFF);
        episode = 0;
        while (items_sent < TARGET_ITEMS) begin
            if (episode == 0 || $urandom_range(11) == 0) begin
                send_plain(KIND_CLEAR, 16'($urandom), $urandom, $urandom, $urandom);
                n = MAX_POINTS_DEF + $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    send_plain(KIND_APPEND, 16'($urandom), pick_coord(), pick_coord(),
                               pick_coord());
            end else begin
                if ($urandom_range(3) == 0)
                    send_plain(KIND_CLEAR, 16'($urandom), $urandom, $urandom, $urandom);
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    send_plain(KIND_APPEND, 16'($urandom), pick_coord(), pick_coord(),
                               pick_coord());
            end
            n = $urandom_range(3, 25);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(19) == 0)
                    send_plain(KIND_UNUSED, 16'($urandom), $urandom, $urandom, $urandom);
                send_plain(KIND_TICK, pick_dt(), $urandom, $urandom, $urandom);
            end
            if ($urandom_range(4) == 0) begin
                if ($urandom_range(1) == 0) write_speed(speeds[$urandom_range(4)]);
                else write_speed(SPEED_W'($urandom_range(0, 24'hFFFFFF)));
            end
            episode++;
        end
        write_speed(SPEED_RESET);
        n = 0;
        while (pending_poses.size() != 0 && n < 200000) begin
            @(negedge aclk);
            n++;
        end
        repeat (600) @(posedge aclk);
        if (errors == 0 && pending_poses.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
